/* hw/rtl/pmbc_pkg.sv */
`timescale 1ns / 1ps

package pmbc_pkg;

  // Word width of the checksum, the modulus and the stored residues.
  localparam int WordW = 32;

  // Widest operand that goes through the serial reducer: residue plus
  // byte times weight needs 32 + 8 + 1 bits.
  localparam int AccW = WordW + 8 + 1;

  // Bit counter wide enough to hold the longest operand length.
  localparam int CntW = $clog2(AccW + 1);

  typedef logic [WordW-1:0] word_t;
  typedef logic [AccW-1:0]  acc_t;
  typedef logic [CntW-1:0]  cnt_t;

  // Operand lengths in bits for the three reductions.
  localparam cnt_t LenSum = cnt_t'(WordW + 1);
  localparam cnt_t LenWgt = cnt_t'(WordW + 8);
  localparam cnt_t LenMac = cnt_t'(AccW);

  // Which register a finished reduction lands in.
  typedef logic [1:0] op_t;
  localparam op_t OP_RES = 2'd0;
  localparam op_t OP_WGT = 2'd1;
  localparam op_t OP_CHK = 2'd2;

  // Request kinds on the input channel.
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_MERGE = 1'b1;

  // Modulus after reset: 2^32 - 5.
  localparam word_t ResetModulus = 32'hFFFF_FFFB;

endpackage

/* hw/rtl/prime_modulus_byte_checksum_top.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: data_byte, merge_word; tuser: req_type;
//                                   tlast: last_byte
// m_*       out  m_tvalid/m_tready  tdata: checksum_out
// cfg_*     in   cfg_we             cfg_wdata: prime_modulus
//
// All sums are reduced by one serial restoring reducer, one bit per cycle.
// A merge transaction runs one reduction, a buffer byte two (residue then
// weight), and the last byte of a buffer two (residue then checksum).
// rst is synchronous; it restores the modulus, clears the checksum and the
// residue and sets the byte weight to one. A stalled output holds its
// transaction; the next input is taken meanwhile and waits before commit.

module prime_modulus_byte_checksum_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,   // [7:0] data_byte, [39:8] merge_word
  input  logic                s_tuser,   // [0] req_type
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output pmbc_pkg::word_t     m_tdata,   // [31:0] checksum_out
  input  logic                cfg_we,
  input  pmbc_pkg::word_t     cfg_wdata
);

  import pmbc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_NEXT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  op_t        op;
  cnt_t       cnt;
  acc_t       opnd;
  word_t      rem;
  logic       is_last;
  logic       is_merge;
  word_t      pm;
  word_t      chk;
  word_t      res;
  word_t      wgt;

  logic [WordW:0]   pm_ext;
  logic [WordW:0]   trial;
  logic [WordW:0]   step_val;
  word_t            step_rem;
  logic [WordW+7:0] mac_prod;
  acc_t             mac_sum;
  logic [WordW:0]   mrg_sum;
  logic [WordW:0]   fin_sum;
  logic             in_fire;
  logic             out_free;

  // A zero modulus stands for 2^32.
  assign pm_ext = {pm == '0, pm};

  // One restoring step: shift in the next operand bit, subtract if it fits.
  assign trial    = {rem, opnd[AccW-1]};
  assign step_val = (trial >= pm_ext) ? (trial - pm_ext) : trial;
  assign step_rem = step_val[WordW-1:0];

  // Operand builders for the three reductions.
  assign mac_prod = s_tdata[7:0] * wgt;
  assign mac_sum  = AccW'(mac_prod) + AccW'(res);
  assign mrg_sum  = {1'b0, chk} + {1'b0, s_tdata[39:8]};
  assign fin_sum  = {1'b0, chk} + {1'b0, res};

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pm <= ResetModulus;
    end else if (cfg_we) begin
      pm <= cfg_wdata;
    end
  end

  // Sequencer and the shared reducer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chk   <= '0;
      res   <= '0;
      wgt   <= word_t'(1);
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            rem      <= '0;
            is_last  <= s_tlast;
            is_merge <= (s_tuser == REQ_MERGE);
            state    <= ST_RUN;
            if (s_tuser == REQ_MERGE) begin
              op   <= OP_CHK;
              opnd <= {mrg_sum, 8'b0};
              cnt  <= LenSum;
            end else begin
              op   <= OP_RES;
              opnd <= mac_sum;
              cnt  <= LenMac;
            end
          end
        end
        ST_RUN: begin
          rem  <= step_rem;
          opnd <= {opnd[AccW-2:0], 1'b0};
          cnt  <= cnt - cnt_t'(1);
          if (cnt == cnt_t'(1)) begin
            case (op)
              OP_RES:  res <= step_rem;
              OP_WGT:  wgt <= step_rem;
              default: chk <= step_rem;
            endcase
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          unique case (op)
            OP_RES: begin
              rem   <= '0;
              state <= ST_RUN;
              if (is_last) begin
                op   <= OP_CHK;
                opnd <= {fin_sum, 8'b0};
                cnt  <= LenSum;
              end else begin
                op   <= OP_WGT;
                opnd <= {wgt, 9'b0};
                cnt  <= LenWgt;
              end
            end
            OP_WGT: begin
              state <= ST_DONE;
            end
            default: begin
              // The end of a buffer starts the next one afresh.
              if (!is_merge) begin
                res <= '0;
                wgt <= word_t'(1);
              end
              state <= ST_DONE;
            end
          endcase
        end
        default: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= chk;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // The partial remainder never reaches the modulus while reducing.
  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> {1'b0, rem} < pm_ext)
    else $error("partial remainder not below modulus");

  // A checksum that was just reduced is below the modulus at commit.
  a_chk_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && op == OP_CHK) |-> {1'b0, chk} < pm_ext)
    else $error("checksum not reduced at commit");

  // An accepted transaction starts the reducer at once.
  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_RUN)
    else $error("accepted transaction did not start the reducer");

  // A new result appears only from the commit state.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result raised outside commit");

endmodule

/* tb/prime_modulus_byte_checksum_top_tb.sv */
`timescale 1ns / 1ps

module prime_modulus_byte_checksum_top_tb;
  import pmbc_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int DrainCycles = 120;
  localparam int RandomItems = 1050;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;    // [7:0] data_byte, [39:8] merge_word
  logic        s_tuser = 1'b0;  // [0] req_type
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  word_t       m_tdata;         // [31:0] checksum_out
  logic        cfg_we = 1'b0;
  word_t       cfg_wdata = '0;

  // Predicted state of the checksum engine.
  word_t model_modulus;
  word_t model_checksum;
  word_t model_residue;
  word_t model_weight;

  word_t pending_checksums[$];
  int    error_count = 0;
  int    cycle_count = 0;
  int    hold_off_left = 0;
  int    burst_left = 0;
  bit    steady_sender = 1'b0;

  prime_modulus_byte_checksum_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Reduction by the current modulus; a zero modulus means plain 32-bit wrap.
  function automatic word_t reduce_word(logic [63:0] x);
    if (model_modulus == '0) begin
      return x[31:0];
    end
    return word_t'(x % {32'd0, model_modulus});
  endfunction

  function automatic word_t add_reduced(word_t a, word_t b);
    return reduce_word(64'(reduce_word(64'(a))) + 64'(reduce_word(64'(b))));
  endfunction

  // Advances the predicted state by one transaction and returns the checksum.
  function automatic word_t predict_checksum(logic req, logic [7:0] data_b, logic is_last,
                                             word_t word_in);
    logic [63:0] weight;
    if (req == REQ_MERGE) begin
      model_checksum = add_reduced(model_checksum, word_in);
    end else begin
      weight = 64'(reduce_word(64'(model_weight)));
      model_residue = reduce_word(64'(reduce_word(64'(model_residue))) + 64'(data_b) * weight);
      model_weight = reduce_word(weight * 64'd256);
      if (is_last) begin
        model_checksum = add_reduced(model_checksum, model_residue);
        model_residue = '0;
        model_weight = 32'd1;
      end
    end
    return model_checksum;
  endfunction

  // Sender bursts: a random number of transactions, then a random gap.
  task automatic sender_pause();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3 || steady_sender) ? 0 : $urandom_range(1, 100);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Offers one transaction and records its expected checksum once accepted.
  task automatic send_item(logic req, logic [7:0] data_b, logic is_last, word_t word_in);
    sender_pause();
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tlast  <= is_last;
    s_tdata  <= {word_in, data_b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_checksums.push_back(predict_checksum(req, data_b, is_last, word_in));
  endtask

  task automatic send_byte(logic [7:0] data_b, logic is_last);
    send_item(REQ_BYTE, data_b, is_last, word_t'($urandom));
  endtask

  task automatic send_merge(word_t word_in);
    send_item(REQ_MERGE, 8'($urandom), 1'($urandom), word_in);
  endtask

  // Stops offering and waits until every expected checksum has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_checksums.size() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(word_t value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_modulus = value;
  endtask

  function automatic word_t pick_modulus();
    case ($urandom_range(0, 9))
      0: return ResetModulus;
      1: return 32'd0;
      2: return 32'd1;
      3: return 32'd2;
      4: return 32'hFFFF_FFFF;
      5: return 32'd251;
      6: return 32'd65521;
      7: return 32'($urandom_range(2, 1000));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Field extremes with the reset modulus, ignored fields and a merge
  // inside an open buffer.
  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    repeat (4) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_merge(32'hFFFF_FFFF);
    send_merge(32'hFFFF_FFFB);
    send_merge(32'hFFFF_FFFA);
    send_item(REQ_MERGE, 8'hFF, 1'b1, 32'h0000_0000);
    send_byte(8'h5A, 1'b0);
    send_merge(32'h1234_5678);
    send_byte(8'hA5, 1'b1);
    send_item(REQ_BYTE, 8'h01, 1'b1, 32'hFFFF_FFFF);
    send_item(REQ_BYTE, 8'h80, 1'b1, 32'h0000_0000);
  endtask

  // Modulus zero, one, two and the largest value, a shrinking modulus with a
  // large checksum, and a modulus change in the middle of a buffer.
  task automatic test_modulus_extremes();
    write_modulus(32'd0);
    send_merge(32'hFFFF_FFFF);
    send_merge(32'd2);
    repeat (4) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    write_modulus(32'hFFFF_FFFF);
    send_merge(32'hFFFF_FFFE);
    send_merge(32'hFFFF_FFFF);
    write_modulus(32'd1);
    send_merge(32'd7);
    send_byte(8'h03, 1'b1);
    write_modulus(32'd2);
    send_merge(32'd3);
    send_byte(8'h01, 1'b0);
    send_byte(8'h01, 1'b1);
    write_modulus(32'hFFFF_FFF0);
    send_merge(32'hFFFF_FFEF);
    write_modulus(32'd251);
    send_byte(8'h80, 1'b0);
    write_modulus(32'd65521);
    send_byte(8'h7F, 1'b1);
    send_merge(32'd0);
    write_modulus(ResetModulus);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // then the sender pauses until all checksums are back.
  task automatic test_long_stall();
    steady_sender = 1'b1;
    hold_off_left = 1200;
    repeat (14) begin
      if ($urandom_range(0, 3) == 0) begin
        send_merge(word_t'($urandom));
      end else begin
        send_byte(8'($urandom), 1'($urandom_range(0, 2) == 0));
      end
    end
    wait_drained();
    steady_sender = 1'b0;
  endtask

  // Mostly well-formed buffers with random content and interleaved merges,
  // some stray last flags, and a new modulus every phase.
  task automatic test_random_stream(int n_items);
    int bytes_left;
    int sent;
    logic is_last;
    bytes_left = 0;
    for (sent = 0; sent < n_items; sent++) begin
      if (sent % 100 == 99) begin
        write_modulus(pick_modulus());
        steady_sender = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < 18) begin
        send_merge(word_t'($urandom));
      end else begin
        if (bytes_left == 0) begin
          bytes_left = ($urandom_range(0, 19) == 0) ? 40 : $urandom_range(1, 12);
        end
        is_last = (bytes_left == 1);
        if ($urandom_range(0, 19) == 0) begin
          is_last = ~is_last;
        end
        bytes_left = is_last ? 0 : bytes_left - 1;
        send_byte(8'($urandom), is_last);
      end
    end
    steady_sender = 1'b0;
  endtask

  // Receiver stalls follow a bit pattern, stretched and re-chosen at random.
  initial begin : receiver
    int phase_left;
    int stretch;
    int stretch_left;
    int idx;
    logic [7:0] pattern;
    phase_left = 0;
    stretch = 1;
    stretch_left = 1;
    idx = 0;
    pattern = 8'hFF;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        m_tready <= 1'b0;
        hold_off_left--;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(32, 400);
          stretch = $urandom_range(1, 10);
          pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom) | 8'h01;
        end
        phase_left--;
        m_tready <= pattern[idx];
        stretch_left--;
        if (stretch_left <= 0) begin
          stretch_left = stretch;
          idx = (idx + 1) % 8;
        end
      end
    end
  end

  // Compare each output transaction with the oldest expected checksum.
  always @(posedge clk) begin : check_results
    word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_checksums.size() == 0) begin
        $display("%0t: unexpected checksum transaction, actual %08h", $time, m_tdata);
        error_count++;
      end else begin
        want = pending_checksums.pop_front();
        if (m_tdata !== want) begin
          $display("%0t: checksum_out mismatch, expected %08h, actual %08h",
                   $time, want, m_tdata);
          error_count++;
        end
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run limit of %0d cycles reached", $time, CycleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : main
    model_modulus  = ResetModulus;
    model_checksum = '0;
    model_residue  = '0;
    model_weight   = 32'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_modulus_extremes();
    test_long_stall();
    test_random_stream(RandomItems);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && pending_checksums.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0t: %0d errors, %0d checksums outstanding", $time, error_count,
               pending_checksums.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pmbc_pkg.sv
hw/rtl/prime_modulus_byte_checksum_top.sv
tb/prime_modulus_byte_checksum_top_tb.sv
